>>> src/pra_pkg.sv
// Shared types and constants for the PID range allocator.
// No dependencies; imported by every module of the block.
package pra_pkg;

  localparam int POOL_SIZE_DEF = 8192;
  localparam int PID_W         = 16;
  localparam int STAT_W        = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int WORD_BITS     = 64;

  localparam logic [PID_W-1:0] MIN_PID_RST = 16'd300;
  localparam logic [PID_W-1:0] MAX_PID_RST = 16'd5000;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PID = 2'd1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RANGE,
    S_CHECK,
    S_SCAN,
    S_READ,
    S_DATA
  } seq_state_t;

  typedef struct packed {
    logic [PID_W-1:0] min_pid;
    logic [PID_W-1:0] max_pid;
  } cfg_t;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

>>> src/pra_lsb_find.sv
// Shared lowest-set-bit finder over one 64-bit word.
// Depends on pra_pkg.
module pra_lsb_find (
  input  logic [pra_pkg::WORD_BITS-1:0] vec,
  output logic                          found,
  output logic [5:0]                    idx
);
  import pra_pkg::*;

  always_comb begin
    found = |vec;
    idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = 6'(i);
      end
    end
  end

endmodule

>>> src/pra_seq.sv
// Sequencer of the allocator: bitmap memory, full-word summary, clear pass
// and the allocate / release steps. Depends on pra_pkg and pra_lsb_find.
module pra_seq #(
  parameter int POOL_SIZE = pra_pkg::POOL_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pra_pkg::cfg_t             cfg,
  input  logic                      start,
  input  logic                      operation,
  input  logic [pra_pkg::PID_W-1:0] pid_in,
  output logic                      busy,
  output logic                      done,
  output pra_pkg::res_t             res
);
  import pra_pkg::*;

  localparam int MAP_WORDS = (POOL_SIZE + WORD_BITS - 1) / WORD_BITS;
  localparam int SUM_WORDS = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CH_W      = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int WI_W      = PID_W - 6;

  seq_state_t state, state_next;

  logic                 op_r;
  logic [PID_W-1:0]     pid_r;
  logic                 empty_r;
  logic [PID_W-1:0]     top_r;
  logic [PID_W-1:0]     span;
  logic [CH_W-1:0]      chunk;
  logic [WI_W-1:0]      word_idx;
  logic [5:0]           bit_r;
  logic [WA_W-1:0]      clr_idx;
  logic [WORD_BITS-1:0] rd_data;

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] sum_words [SUM_WORDS];

  // combinational controls
  logic [PID_W:0]       limit;
  logic [PID_W-1:0]     offset;
  logic                 in_range;
  logic [WORD_BITS-1:0] sum_chunk;
  logic [WORD_BITS-1:0] chunk_mask;
  logic [WORD_BITS-1:0] word_mask;
  logic                 last_chunk;
  logic                 clr_last;
  logic [WORD_BITS-1:0] enc_in;
  logic                 enc_found;
  logic [5:0]           enc_idx;
  logic                 mem_we;
  logic [WA_W-1:0]      mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 sum_we;
  logic                 sum_bit;
  logic [CH_W-1:0]      sum_sel;
  logic                 fin;
  res_t                 fin_res;
  logic [WORD_BITS-1:0] set_word;
  logic [WORD_BITS-1:0] clr_word;

  pra_lsb_find u_find (
    .vec   (enc_in),
    .found (enc_found),
    .idx   (enc_idx)
  );

  assign limit      = {1'b0, cfg.min_pid} + (PID_W+1)'(POOL_SIZE - 1);
  assign offset     = pid_r - cfg.min_pid;
  // top_r is settled by the time the range check runs
  assign in_range   = (pid_r >= cfg.min_pid) && (pid_r <= top_r);
  assign sum_chunk  = sum_words[chunk];
  assign last_chunk = (chunk == CH_W'(span[PID_W-1:12]));
  assign clr_last   = (clr_idx == WA_W'(MAP_WORDS - 1));
  assign chunk_mask = last_chunk ? ({WORD_BITS{1'b1}} >> (6'd63 - span[11:6]))
                                 : {WORD_BITS{1'b1}};
  assign word_mask  = (word_idx == span[PID_W-1:6])
                    ? ({WORD_BITS{1'b1}} >> (6'd63 - span[5:0]))
                    : {WORD_BITS{1'b1}};
  assign set_word   = rd_data | (WORD_BITS'(1) << enc_idx);
  assign clr_word   = rd_data & ~(WORD_BITS'(1) << bit_r);
  assign sum_sel    = CH_W'(word_idx[WI_W-1:6]);
  assign busy       = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_RANGE;
      end
      S_RANGE: state_next = S_CHECK;
      S_CHECK: begin
        if (empty_r) state_next = S_IDLE;
        else if (op_r == OP_ALLOC) state_next = S_SCAN;
        else if (in_range) state_next = S_READ;
        else state_next = S_IDLE;
      end
      S_SCAN: begin
        if (enc_found) state_next = S_READ;
        else if (last_chunk) state_next = S_IDLE;
      end
      S_READ: state_next = S_DATA;
      S_DATA: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of each step
  always_comb begin
    enc_in     = '0;
    mem_we     = 1'b0;
    mem_waddr  = word_idx[WA_W-1:0];
    mem_wdata  = '0;
    sum_we     = 1'b0;
    sum_bit    = 1'b0;
    fin        = 1'b0;
    fin_res    = '{pid: '0, status: STAT_OK};
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
      end
      S_CHECK: begin
        if (empty_r || (op_r == OP_RELEASE && !in_range)) begin
          fin            = 1'b1;
          fin_res.status = (op_r == OP_ALLOC) ? STAT_EXHAUSTED : STAT_NOT_ALLOC;
        end
      end
      S_SCAN: begin
        enc_in = ~sum_chunk & chunk_mask;
        if (!enc_found && last_chunk) begin
          fin            = 1'b1;
          fin_res.status = STAT_EXHAUSTED;
        end
      end
      S_DATA: begin
        fin = 1'b1;
        if (op_r == OP_ALLOC) begin
          enc_in = ~rd_data & word_mask;
          if (enc_found) begin
            mem_we      = 1'b1;
            mem_wdata   = set_word;
            sum_we      = 1'b1;
            sum_bit     = &set_word;
            fin_res.pid = cfg.min_pid + {word_idx, enc_idx};
          end else begin
            fin_res.status = STAT_EXHAUSTED;
          end
        end else begin
          if (rd_data[bit_r]) begin
            mem_we      = 1'b1;
            mem_wdata   = clr_word;
            sum_we      = 1'b1;
            fin_res.pid = pid_r;
          end else begin
            fin_res.status = STAT_NOT_ALLOC;
          end
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (state == S_CLEAR) clr_idx <= clr_idx + WA_W'(1);
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_r  <= operation;
      pid_r <= pid_in;
    end
    if (state == S_RANGE) begin
      empty_r <= (cfg.min_pid > cfg.max_pid);
      top_r   <= ({1'b0, cfg.max_pid} < limit) ? cfg.max_pid : limit[PID_W-1:0];
    end
    if (state == S_CHECK) begin
      span     <= top_r - cfg.min_pid;
      chunk    <= '0;
      word_idx <= offset[PID_W-1:6];
      bit_r    <= offset[5:0];
    end
    if (state == S_SCAN) begin
      if (enc_found) word_idx <= (WI_W'(chunk) << 6) | WI_W'(enc_idx);
      else chunk <= chunk + CH_W'(1);
    end
    if (fin) res <= fin_res;
  end

  // bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    if (state == S_READ) rd_data <= map_mem[word_idx[WA_W-1:0]];
  end

  // full-word summary, one bit per bitmap word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SUM_WORDS; i++) sum_words[i] <= '0;
    end else if (sum_we) begin
      sum_words[sum_sel][word_idx[5:0]] <= sum_bit;
    end
  end

endmodule

>>> src/pid_range_allocator_top.sv
// Top level of the PID range allocator: configuration registers and the
// command interface. Depends on pra_pkg and pra_seq.
//
// Hands out process identifiers from min_pid up to min(max_pid,
// min_pid + POOL_SIZE - 1), lowest free first, and takes them back on
// release. A transaction is accepted when start is high and busy is low;
// its result appears on pid_out/status with done high for exactly one
// cycle, and the receiver cannot stall it. After reset the block sweeps
// the bitmap memory clear, one word per cycle, while busy stays high. An
// allocate searches one summary chunk of 64 words per cycle with the
// shared 64-bit lowest-bit finder, then reads and updates the selected
// bitmap word. An allocate that finds every summary chunk full ends
// exhausted after the search. A release runs a range check, a word read
// and a write back; errors found in the range check finish there. A new
// transaction may start in the cycle done is high. Configuration writes
// are always ready and should be issued only while the block is idle.
module pid_range_allocator_top #(
  parameter int POOL_SIZE = pra_pkg::POOL_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [pra_pkg::PID_W-1:0]     pid_in,
  // result strobe
  output logic                          done,
  output logic [pra_pkg::PID_W-1:0]     pid_out,
  output logic [pra_pkg::STAT_W-1:0]    status,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pra_pkg::PID_W-1:0]     cfg_data
);
  import pra_pkg::*;

  cfg_t cfg;
  res_t res;

  // register file never backpressures
  assign cfg_ready = 1'b1;

  // unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pid <= MIN_PID_RST;
      cfg.max_pid <= MAX_PID_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_PID: cfg.min_pid <= cfg_data;
        CFG_MAX_PID: cfg.max_pid <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer owns the bitmap and the search
  pra_seq #(
    .POOL_SIZE (POOL_SIZE)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .operation (operation),
    .pid_in    (pid_in),
    .busy      (busy),
    .done      (done),
    .res       (res)
  );

  assign pid_out = res.pid;
  assign status  = res.status;

endmodule

>>> src/pra_checker.sv
// Port-level checker for the PID range allocator, bound to the top level.
// Depends on pra_pkg.
module pra_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [pra_pkg::PID_W-1:0]     pid_out,
  input logic [pra_pkg::STAT_W-1:0]    status
);
  import pra_pkg::*;

  // an accepted transaction keeps the block busy until its result
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted transaction");

  // one result per transaction, never two in a row
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done high on two consecutive cycles");

  // a result comes only out of a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in flight");

  // status codes and zero identifier on error
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STAT_OK || status == STAT_EXHAUSTED || status == STAT_NOT_ALLOC))
    else $error("illegal status code");

  a_err_zero_pid: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (pid_out == '0))
    else $error("nonzero identifier reported with an error");

endmodule

bind pid_range_allocator_top pra_checker u_pra_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .pid_out (pid_out),
  .status  (status)
);
